[rtl/wsrc_pkg.sv]
// Shared types and constants for the wheel speed ramp controller.
// No dependencies; every other file in rtl imports this package.
`default_nettype none

package wsrc_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int TICK_W      = 28;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [14:0] BASE_SPEED_RESET = 15'd140;
    localparam logic [7:0]  RAMP_INC_RESET   = 8'd10;
    localparam logic [7:0]  POLL_TICKS_RESET = 8'd10;
    localparam logic [14:0] SPEED_LIMIT_RESET = 15'(int'(BASE_SPEED_RESET) * 3 / 2);
    localparam logic [14:0] SPEED_LIMIT_MAX  = 15'd32767;

    // Exact unsigned divide by ten for 32-bit values: (x * RECIP10) >> RECIP10_SHIFT
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    localparam logic signed [16:0] CORR_MAX = 17'sd65535;

    typedef enum logic [1:0] {
        ACT_COMMAND = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_ODO     = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        DIR_STOP    = 3'd0,
        DIR_FORWARD = 3'd1,
        DIR_BACK    = 3'd2,
        DIR_LEFT    = 3'd3,
        DIR_RIGHT   = 3'd4
    } direction_t;

    typedef enum logic [1:0] {
        OP_STOP = 2'd0,
        OP_MOVE = 2'd1,
        OP_TICK = 2'd2,
        OP_ODO  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MOVE_FORWARD = 2'd0,
        MOVE_BACK    = 2'd1,
        MOVE_LEFT    = 2'd2,
        MOVE_RIGHT   = 2'd3
    } move_t;

    typedef enum logic [1:0] {
        KIND_SPEED  = 2'd0,
        KIND_STOP   = 2'd1,
        KIND_STATUS = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_BASE_SPEED = 2'd0,
        REG_RAMP_INC   = 2'd1,
        REG_POLL_TICKS = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        op_t                op;
        move_t              move;
        logic               held;
        logic [TICK_W-1:0]  ticks;
        logic signed [32:0] odo_diff;
    } item_word_t;

    typedef struct packed {
        logic [14:0] base_speed;
        logic [7:0]  ramp_inc;
        logic [7:0]  poll_ticks;
        logic [14:0] speed_limit;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
    } frame_t;

endpackage

`default_nettype wire

[rtl/wsrc_front.sv]
// Front end: accepts input words, drops ignored ones, decodes the rest.
// Depends on wsrc_pkg; feeds wsrc_queue.
`default_nettype none

module wsrc_front (
    input  wire logic                       item_valid,
    output logic                            item_ready,
    input  wire logic [1:0]                 action,
    input  wire logic [2:0]                 direction,
    input  wire logic signed [31:0]         run_length,
    input  wire logic signed [31:0]         odo_left_count,
    input  wire logic signed [31:0]         odo_right_count,
    output logic                            push_valid,
    output wsrc_pkg::item_word_t            push_word,
    input  wire logic                       push_ready
);
    import wsrc_pkg::*;

    logic              keep;
    logic              dur_pos;
    logic [62:0]       prod;
    logic [TICK_W-1:0] quot;

    assign item_ready = push_ready;
    assign push_valid = item_valid && keep;

    assign dur_pos = !run_length[31] && (run_length != 32'sd0);
    assign prod    = {32'd0, run_length[30:0]} * {31'd0, RECIP10};
    assign quot    = prod[RECIP10_SHIFT +: TICK_W];

    always_comb
    begin
        keep               = 1'b0;
        push_word.op       = OP_TICK;
        push_word.move     = MOVE_FORWARD;
        push_word.held     = !dur_pos;
        push_word.ticks    = '0;
        push_word.odo_diff = {odo_right_count[31], odo_right_count}
                           - {odo_left_count[31], odo_left_count};
        if (dur_pos)
        begin
            push_word.ticks = (quot == '0) ? TICK_W'(1) : quot;
        end
        case (action_t'(action))
            ACT_COMMAND:
            begin
                keep = 1'b1;
                case (direction_t'(direction))
                    DIR_STOP:    push_word.op = OP_STOP;
                    DIR_FORWARD:
                    begin
                        push_word.op   = OP_MOVE;
                        push_word.move = MOVE_FORWARD;
                    end
                    DIR_BACK:
                    begin
                        push_word.op   = OP_MOVE;
                        push_word.move = MOVE_BACK;
                    end
                    DIR_LEFT:
                    begin
                        push_word.op   = OP_MOVE;
                        push_word.move = MOVE_LEFT;
                    end
                    DIR_RIGHT:
                    begin
                        push_word.op   = OP_MOVE;
                        push_word.move = MOVE_RIGHT;
                    end
                    default:     keep = 1'b0;
                endcase
            end
            ACT_TICK:
            begin
                keep         = 1'b1;
                push_word.op = OP_TICK;
            end
            ACT_ODO:
            begin
                keep         = 1'b1;
                push_word.op = OP_ODO;
            end
            default:     keep = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/wsrc_queue.sv]
// Short register queue of decoded words between front and back.
// Depends on wsrc_pkg for the word type.
`default_nettype none

module wsrc_queue #(
    parameter int DEPTH = wsrc_pkg::QUEUE_DEPTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push_valid,
    output logic                       push_ready,
    input  wire wsrc_pkg::item_word_t  push_word,
    output logic                       head_valid,
    output wsrc_pkg::item_word_t       head_word,
    input  wire logic                  head_pop
);
    import wsrc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_word_t         entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_word  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = head_pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not grow on push");

    a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

[rtl/wsrc_back.sv]
// Back end: executes decoded words against the run state and sequences result frames.
// Depends on wsrc_pkg; pops wsrc_queue and drives the output register.
`default_nettype none

module wsrc_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire wsrc_pkg::cfg_t        cfg,
    input  wire logic                  head_valid,
    input  wire wsrc_pkg::item_word_t  head_word,
    output logic                       head_pop,
    output logic                       frame_valid,
    input  wire logic                  frame_ready,
    output logic [1:0]                 frame_kind,
    output logic signed [15:0]         left_speed,
    output logic signed [15:0]         right_speed,
    output logic                       last
);
    import wsrc_pkg::*;

    function automatic logic signed [15:0] step_toward(
        input logic signed [15:0] cur,
        input logic signed [15:0] tgt,
        input logic [7:0]         inc
    );
        logic signed [16:0] up;
        logic signed [16:0] dn;
        logic signed [16:0] tgt_x;
        logic signed [15:0] res;
        up    = {cur[15], cur} + {9'd0, inc};
        dn    = {cur[15], cur} - {9'd0, inc};
        tgt_x = {tgt[15], tgt};
        res   = cur;
        if (cur < tgt)
        begin
            res = (up > tgt_x) ? tgt : up[15:0];
        end
        else if (cur > tgt)
        begin
            res = (dn < tgt_x) ? tgt : dn[15:0];
        end
        return res;
    endfunction

    logic                running_reg, running_next;
    logic                held_reg, held_next;
    logic signed [15:0]  tl_reg, tl_next;
    logic signed [15:0]  tr_reg, tr_next;
    logic signed [15:0]  rl_reg, rl_next;
    logic signed [15:0]  rr_reg, rr_next;
    logic [TICK_W-1:0]   ticks_reg, ticks_next;
    logic                drift_reg, drift_next;
    logic [7:0]          poll_reg, poll_next;
    logic signed [32:0]  latest_diff_reg, latest_diff_next;
    logic signed [32:0]  base_diff_reg, base_diff_next;
    logic signed [16:0]  corr_reg, corr_next;
    logic                fresh_reg, fresh_next;

    frame_t              slot_reg [3];
    frame_t              slot_next [3];
    logic [2:0]          slot_valid_reg, slot_valid_next;
    frame_t              out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    frame_t              new_frame [3];
    logic [2:0]          new_valid;

    logic                out_free;
    logic                advance;

    logic signed [15:0]  base_s;
    logic signed [15:0]  rl_step, rr_step;
    logic [7:0]          poll_inc;
    logic                status_ev;
    logic                stop_ev;
    logic                drift_on;
    logic signed [17:0]  sum_l, sum_r, lim_s;
    logic signed [15:0]  clamp_l, clamp_r;
    logic signed [15:0]  spd_l, spd_r;
    logic signed [33:0]  corr_d, corr_h;
    logic                tick_live;

    assign out_free = !out_valid_reg || frame_ready;
    assign advance  = out_free && slot_valid_reg[0];
    assign head_pop = head_valid && (!slot_valid_reg[0] || (advance && !slot_valid_reg[1]));

    assign frame_valid = out_valid_reg;
    assign frame_kind  = out_reg.kind;
    assign left_speed  = out_reg.left;
    assign right_speed = out_reg.right;
    assign last        = out_reg.last;

    // tick datapath
    assign base_s    = {1'b0, cfg.base_speed};
    assign rl_step   = step_toward(rl_reg, tl_reg, cfg.ramp_inc);
    assign rr_step   = step_toward(rr_reg, tr_reg, cfg.ramp_inc);
    assign poll_inc  = poll_reg + 8'd1;
    assign status_ev = (poll_inc >= cfg.poll_ticks);
    assign stop_ev   = (tl_reg == 16'sd0) && (tr_reg == 16'sd0)
                    && (rl_step == 16'sd0) && (rr_step == 16'sd0);
    assign drift_on  = drift_reg && (tl_reg == tr_reg) && (tl_reg != 16'sd0)
                    && (rl_step == rr_step);
    assign lim_s     = {3'd0, cfg.speed_limit};
    assign sum_l     = {{2{rl_step[15]}}, rl_step} + {corr_reg[16], corr_reg};
    assign sum_r     = {{2{rr_step[15]}}, rr_step} - {corr_reg[16], corr_reg};
    assign tick_live = (head_word.op == OP_TICK) && running_reg;

    always_comb
    begin
        if (sum_l > lim_s)
        begin
            clamp_l = lim_s[15:0];
        end
        else if (sum_l < -lim_s)
        begin
            clamp_l = -lim_s[15:0];
        end
        else
        begin
            clamp_l = sum_l[15:0];
        end
        if (sum_r > lim_s)
        begin
            clamp_r = lim_s[15:0];
        end
        else if (sum_r < -lim_s)
        begin
            clamp_r = -lim_s[15:0];
        end
        else
        begin
            clamp_r = sum_r[15:0];
        end
        spd_l = rl_step;
        spd_r = rr_step;
        if (drift_on)
        begin
            spd_r = clamp_r;
            spd_l = clamp_l;
            // keep the left wheel from reversing
            if ((rl_step > 16'sd0 && clamp_l < 16'sd0) || (rl_step < 16'sd0 && clamp_l > 16'sd0))
            begin
                spd_l = 16'sd0;
            end
        end
    end

    // drift correction refresh on odometry words
    assign corr_d = {head_word.odo_diff[32], head_word.odo_diff}
                  - {base_diff_reg[32], base_diff_reg};
    assign corr_h = (corr_d + $signed({33'd0, corr_d[33]})) >>> 1;

    always_comb
    begin
        running_next     = running_reg;
        held_next        = held_reg;
        tl_next          = tl_reg;
        tr_next          = tr_reg;
        rl_next          = rl_reg;
        rr_next          = rr_reg;
        ticks_next       = ticks_reg;
        drift_next       = drift_reg;
        poll_next        = poll_reg;
        latest_diff_next = latest_diff_reg;
        base_diff_next   = base_diff_reg;
        corr_next        = corr_reg;
        fresh_next       = fresh_reg;
        new_valid        = 3'b000;
        for (int i = 0; i < 3; i++)
        begin
            new_frame[i] = '{kind: KIND_STOP, left: 16'sd0, right: 16'sd0, last: 1'b1};
        end

        if (head_pop)
        begin
            case (head_word.op)
                OP_STOP:
                begin
                    tl_next    = 16'sd0;
                    tr_next    = 16'sd0;
                    held_next  = 1'b0;
                    ticks_next = '0;
                    drift_next = 1'b0;
                    if (!running_reg)
                    begin
                        rl_next      = 16'sd0;
                        rr_next      = 16'sd0;
                        new_valid[0] = 1'b1;
                    end
                end
                OP_MOVE:
                begin
                    case (head_word.move)
                        MOVE_FORWARD:
                        begin
                            tl_next = base_s;
                            tr_next = base_s;
                        end
                        MOVE_BACK:
                        begin
                            tl_next = -base_s;
                            tr_next = -base_s;
                        end
                        MOVE_LEFT:
                        begin
                            tl_next = -base_s;
                            tr_next = base_s;
                        end
                        MOVE_RIGHT:
                        begin
                            tl_next = base_s;
                            tr_next = -base_s;
                        end
                        default:
                        begin
                            tl_next = base_s;
                            tr_next = base_s;
                        end
                    endcase
                    held_next    = head_word.held;
                    ticks_next   = head_word.ticks;
                    drift_next   = fresh_reg;
                    if (fresh_reg)
                    begin
                        base_diff_next = latest_diff_reg;
                        corr_next      = 17'sd0;
                    end
                    poll_next    = 8'd0;
                    running_next = 1'b1;
                end
                OP_ODO:
                begin
                    latest_diff_next = head_word.odo_diff;
                    fresh_next       = 1'b1;
                    if (corr_h > 34'sd65535)
                    begin
                        corr_next = CORR_MAX;
                    end
                    else if (corr_h < -34'sd65535)
                    begin
                        corr_next = -CORR_MAX;
                    end
                    else
                    begin
                        corr_next = corr_h[16:0];
                    end
                end
                OP_TICK:
                begin
                    if (running_reg)
                    begin
                        rl_next   = rl_step;
                        rr_next   = rr_step;
                        poll_next = status_ev ? 8'd0 : poll_inc;
                        if ((tl_reg == 16'sd0) && (tr_reg == 16'sd0))
                        begin
                            if (stop_ev)
                            begin
                                running_next = 1'b0;
                            end
                        end
                        else if (!held_reg)
                        begin
                            if (ticks_reg <= TICK_W'(1))
                            begin
                                ticks_next = '0;
                                tl_next    = 16'sd0;
                                tr_next    = 16'sd0;
                                drift_next = 1'b0;
                            end
                            else
                            begin
                                ticks_next = ticks_reg - 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    running_next = running_reg;
                end
            endcase

            if (tick_live)
            begin
                new_valid[0] = 1'b1;
                new_valid[1] = status_ev || stop_ev;
                new_valid[2] = status_ev && stop_ev;
                if (status_ev)
                begin
                    new_frame[0] = '{kind: KIND_STATUS, left: 16'sd0, right: 16'sd0, last: 1'b0};
                    new_frame[1] = '{kind: KIND_SPEED, left: spd_l, right: spd_r, last: !stop_ev};
                end
                else
                begin
                    new_frame[0] = '{kind: KIND_SPEED, left: spd_l, right: spd_r, last: !stop_ev};
                end
            end
        end
    end

    always_comb
    begin
        slot_next       = slot_reg;
        slot_valid_next = slot_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        if (advance)
        begin
            out_next        = slot_reg[0];
            out_valid_next  = 1'b1;
            slot_next[0]    = slot_reg[1];
            slot_next[1]    = slot_reg[2];
            slot_valid_next = {1'b0, slot_valid_reg[2:1]};
        end
        else if (frame_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (head_pop)
        begin
            slot_next       = new_frame;
            slot_valid_next = new_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg     <= 1'b0;
            held_reg        <= 1'b0;
            tl_reg          <= 16'sd0;
            tr_reg          <= 16'sd0;
            rl_reg          <= 16'sd0;
            rr_reg          <= 16'sd0;
            ticks_reg       <= '0;
            drift_reg       <= 1'b0;
            poll_reg        <= 8'd0;
            latest_diff_reg <= 33'sd0;
            base_diff_reg   <= 33'sd0;
            corr_reg        <= 17'sd0;
            fresh_reg       <= 1'b0;
            slot_valid_reg  <= 3'b000;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            running_reg     <= running_next;
            held_reg        <= held_next;
            tl_reg          <= tl_next;
            tr_reg          <= tr_next;
            rl_reg          <= rl_next;
            rr_reg          <= rr_next;
            ticks_reg       <= ticks_next;
            drift_reg       <= drift_next;
            poll_reg        <= poll_next;
            latest_diff_reg <= latest_diff_next;
            base_diff_reg   <= base_diff_next;
            corr_reg        <= corr_next;
            fresh_reg       <= fresh_next;
            slot_valid_reg  <= slot_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        out_reg  <= out_next;
    end

    a_slots_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_valid_reg[1] |-> slot_valid_reg[0]) and (slot_valid_reg[2] |-> slot_valid_reg[1]))
        else $error("pending frames not packed toward the head");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> (!slot_valid_reg[1] && (!slot_valid_reg[0] || advance)))
        else $error("word popped while frames still pending");

    a_idle_frames_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind != KIND_SPEED) |-> (out_reg.left == 16'sd0
            && out_reg.right == 16'sd0))
        else $error("stop or status frame carries a speed");

    a_stop_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (head_pop && tick_live && stop_ev) |=> (!running_reg && slot_valid_reg[0]))
        else $error("run not ended after final stop frame");

endmodule

`default_nettype wire

[rtl/wheel_speed_ramp_controller_core.sv]
// Path: queue register, then pending frame slots, then the output register.
// Throughput: one input word per cycle unless stalled; a tick with k frames holds later words.
// The output register and the decoded-word queue let input and output stall independently.
// Reset (rst_n low, asynchronous) clears the run state, the queue and the output register,
// and loads base_speed 140, ramp_increment 10, status_poll_ticks 10.
`default_nettype none

module wheel_speed_ramp_controller_core #(
    parameter int QUEUE_DEPTH = wsrc_pkg::QUEUE_DEPTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [wsrc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [wsrc_pkg::DATA_W-1:0]  pwdata,
    output logic [wsrc_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire logic [1:0]                   action,
    input  wire logic [2:0]                   direction,
    input  wire logic signed [31:0]           run_length,
    input  wire logic signed [31:0]           odo_left_count,
    input  wire logic signed [31:0]           odo_right_count,
    output logic                              frame_valid,
    input  wire logic                         frame_ready,
    output logic [1:0]                        frame_kind,
    output logic signed [15:0]                left_speed,
    output logic signed [15:0]                right_speed,
    output logic                              last
);
    import wsrc_pkg::*;

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        cfg_write;
    cfg_reg_t    cfg_sel;
    logic [15:0] limit_raw;

    logic        push_valid;
    logic        push_ready;
    item_word_t  push_word;
    logic        head_valid;
    item_word_t  head_word;
    logic        head_pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = cfg_reg_t'(paddr[3:2]);
    assign limit_raw = {1'b0, cfg_reg.base_speed} + {2'b00, cfg_reg.base_speed[14:1]};

    always_comb
    begin
        cfg_next             = cfg_reg;
        cfg_next.speed_limit = limit_raw[15] ? SPEED_LIMIT_MAX : limit_raw[14:0];
        if (cfg_write)
        begin
            case (cfg_sel)
                REG_BASE_SPEED: cfg_next.base_speed = pwdata[14:0];
                REG_RAMP_INC:   cfg_next.ramp_inc   = pwdata[7:0];
                REG_POLL_TICKS: cfg_next.poll_ticks = pwdata[7:0];
                default:        cfg_next.base_speed = cfg_reg.base_speed;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_BASE_SPEED: prdata = {17'd0, cfg_reg.base_speed};
            REG_RAMP_INC:   prdata = {24'd0, cfg_reg.ramp_inc};
            REG_POLL_TICKS: prdata = {24'd0, cfg_reg.poll_ticks};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_speed  <= BASE_SPEED_RESET;
            cfg_reg.ramp_inc    <= RAMP_INC_RESET;
            cfg_reg.poll_ticks  <= POLL_TICKS_RESET;
            cfg_reg.speed_limit <= SPEED_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    wsrc_front u_front (
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .action          (action),
        .direction       (direction),
        .run_length      (run_length),
        .odo_left_count  (odo_left_count),
        .odo_right_count (odo_right_count),
        .push_valid      (push_valid),
        .push_word       (push_word),
        .push_ready      (push_ready)
    );

    wsrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_word  (push_word),
        .head_valid (head_valid),
        .head_word  (head_word),
        .head_pop   (head_pop)
    );

    wsrc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head_valid  (head_valid),
        .head_word   (head_word),
        .head_pop    (head_pop),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_kind  (frame_kind),
        .left_speed  (left_speed),
        .right_speed (right_speed),
        .last        (last)
    );

endmodule

`default_nettype wire

[sim/wheel_speed_ramp_controller_core_tb.sv]
// Self-checking bench for wheel_speed_ramp_controller_core: a running model of the ramp,
// status poll and drift correction predicts every frame, and a monitor checks them in order.
// Depends on rtl/wsrc_pkg.sv and rtl/wheel_speed_ramp_controller_core.sv.

module wheel_speed_ramp_controller_core_tb;
    import wsrc_pkg::*;

    localparam logic [2:0] DIR_UNKNOWN  = 3'd5;
    localparam int         DRAIN_CYCLES = 10;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         HOLD_AFTER   = 40;
    localparam int         IDLE_PCT     = 17;

    typedef struct {
        logic [1:0]         act;
        logic [2:0]         dir;
        logic signed [31:0] dur_ms;
        logic signed [31:0] left_cnt;
        logic signed [31:0] right_cnt;
    } move_word_t;

    logic                 clk             = 1'b0;
    logic                 rst_n           = 1'b0;
    logic                 psel            = 1'b0;
    logic                 penable         = 1'b0;
    logic                 pwrite          = 1'b0;
    logic [ADDR_W-1:0]    paddr           = '0;
    logic [DATA_W-1:0]    pwdata          = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 item_valid      = 1'b0;
    logic                 item_ready;
    logic [1:0]           action          = '0;
    logic [2:0]           direction       = '0;
    logic signed [31:0]   run_length      = '0;
    logic signed [31:0]   odo_left_count  = '0;
    logic signed [31:0]   odo_right_count = '0;
    logic                 frame_valid;
    logic                 frame_ready     = 1'b0;
    logic [1:0]           frame_kind;
    logic signed [15:0]   left_speed;
    logic signed [15:0]   right_speed;
    logic                 last;

    logic                 rx_block = 1'b0;
    logic                 calm     = 1'b0;
    int                   accepted_cnt = 0;
    int                   err_cnt      = 0;
    move_word_t           word_queue[$];
    move_word_t           next_word;
    frame_t               frames_due[$];
    frame_t               want_frame;

    logic [14:0]          cfg_base = BASE_SPEED_RESET;
    logic [7:0]           cfg_ramp = RAMP_INC_RESET;
    logic [7:0]           cfg_poll = POLL_TICKS_RESET;
    logic                 run_on   = 1'b0;
    logic                 held_run = 1'b0;
    logic signed [15:0]   tgt_l    = '0;
    logic signed [15:0]   tgt_r    = '0;
    logic signed [15:0]   ramp_l   = '0;
    logic signed [15:0]   ramp_r   = '0;
    logic [TICK_W-1:0]    ticks_rem = '0;
    logic signed [31:0]   base_l   = '0;
    logic signed [31:0]   base_r   = '0;
    logic                 drift_on = 1'b0;
    logic [7:0]           poll_cnt = '0;
    logic signed [31:0]   latest_l = '0;
    logic signed [31:0]   latest_r = '0;
    logic                 odo_seen = 1'b0;

    wheel_speed_ramp_controller_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .action          (action),
        .direction       (direction),
        .run_length      (run_length),
        .odo_left_count  (odo_left_count),
        .odo_right_count (odo_right_count),
        .frame_valid     (frame_valid),
        .frame_ready     (frame_ready),
        .frame_kind      (frame_kind),
        .left_speed      (left_speed),
        .right_speed     (right_speed),
        .last            (last)
    );

    always #5 clk = ~clk;

    function automatic void add_frame(input kind_t k, input logic signed [15:0] l,
                                      input logic signed [15:0] r);
        frames_due.push_back('{kind: k, left: l, right: r, last: 1'b0});
    endfunction

    function automatic logic signed [15:0] step_toward(input logic signed [15:0] cur,
                                                       input logic signed [15:0] goal);
        int v;
        v = cur;
        if (cur < goal)
        begin
            v = v + int'(cfg_ramp);
            if (v > goal)
                v = goal;
        end
        else if (cur > goal)
        begin
            v = v - int'(cfg_ramp);
            if (v < goal)
                v = goal;
        end
        return 16'(v);
    endfunction

    function automatic longint clamp_speed(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic void predict_frames(input logic [1:0] act, input logic [2:0] dir,
                                           input logic signed [31:0] dur,
                                           input logic signed [31:0] cnt_l,
                                           input logic signed [31:0] cnt_r);
        int                 n_before;
        logic signed [15:0] spd;
        longint             drift;
        longint             corr;
        longint             lim;
        longint             out_l;
        longint             out_r;
        n_before = frames_due.size();
        spd = {1'b0, cfg_base};
        case (act)
            ACT_COMMAND:
            begin
                if (dir == DIR_STOP)
                begin
                    tgt_l = '0;
                    tgt_r = '0;
                    held_run = 1'b0;
                    ticks_rem = '0;
                    drift_on = 1'b0;
                    if (!run_on)
                    begin
                        ramp_l = '0;
                        ramp_r = '0;
                        add_frame(KIND_STOP, '0, '0);
                    end
                end
                else if (dir < DIR_UNKNOWN)
                begin
                    case (dir)
                        DIR_FORWARD: begin tgt_l = spd;  tgt_r = spd;  end
                        DIR_BACK:    begin tgt_l = -spd; tgt_r = -spd; end
                        DIR_LEFT:    begin tgt_l = -spd; tgt_r = spd;  end
                        default:     begin tgt_l = spd;  tgt_r = -spd; end
                    endcase
                    if (dur > 0)
                    begin
                        held_run = 1'b0;
                        ticks_rem = TICK_W'(dur / 10);
                        if (ticks_rem == '0)
                            ticks_rem = TICK_W'(1);
                    end
                    else
                    begin
                        held_run = 1'b1;
                        ticks_rem = '0;
                    end
                    drift_on = odo_seen;
                    if (odo_seen)
                    begin
                        base_l = latest_l;
                        base_r = latest_r;
                    end
                    poll_cnt = '0;
                    run_on = 1'b1;
                end
            end
            ACT_TICK:
            begin
                if (run_on)
                begin
                    ramp_l = step_toward(ramp_l, tgt_l);
                    ramp_r = step_toward(ramp_r, tgt_r);
                    poll_cnt = poll_cnt + 8'd1;
                    if (poll_cnt >= cfg_poll)
                    begin
                        poll_cnt = '0;
                        add_frame(KIND_STATUS, '0, '0);
                    end
                    out_l = ramp_l;
                    out_r = ramp_r;
                    if (drift_on && tgt_l == tgt_r && tgt_l != 0 && ramp_l == ramp_r)
                    begin
                        drift = (longint'(latest_r) - base_r) - (longint'(latest_l) - base_l);
                        corr = drift / 2;
                        lim = longint'(cfg_base) * 3 / 2;
                        if (lim > 32767)
                            lim = 32767;
                        out_l = clamp_speed(ramp_l + corr, lim);
                        out_r = clamp_speed(ramp_r - corr, lim);
                        if (ramp_l > 0 && out_l < 0)
                            out_l = 0;
                        if (ramp_l < 0 && out_l > 0)
                            out_l = 0;
                    end
                    add_frame(KIND_SPEED, 16'(out_l), 16'(out_r));
                    if (tgt_l == 0 && tgt_r == 0)
                    begin
                        if (ramp_l == 0 && ramp_r == 0)
                        begin
                            add_frame(KIND_STOP, '0, '0);
                            run_on = 1'b0;
                        end
                    end
                    else if (!held_run)
                    begin
                        if (ticks_rem <= 1)
                        begin
                            ticks_rem = '0;
                            tgt_l = '0;
                            tgt_r = '0;
                            drift_on = 1'b0;
                        end
                        else
                        begin
                            ticks_rem = ticks_rem - 1;
                        end
                    end
                end
            end
            ACT_ODO:
            begin
                latest_l = cnt_l;
                latest_r = cnt_r;
                odo_seen = 1'b1;
            end
            default: ;
        endcase
        if (frames_due.size() > n_before)
            frames_due[$].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_cnt++;
        $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic push_item(input logic [1:0] a, input logic [2:0] d,
                             input logic signed [31:0] t, input logic signed [31:0] l,
                             input logic signed [31:0] r);
        word_queue.push_back('{act: a, dir: d, dur_ms: t, left_cnt: l, right_cnt: r});
    endtask

    task automatic push_tick();
        push_item(ACT_TICK, 3'($urandom), $urandom, $urandom, $urandom);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BASE_SPEED: cfg_base = val[14:0];
            REG_RAMP_INC:   cfg_ramp = val[7:0];
            REG_POLL_TICKS: cfg_poll = val[7:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        wait (word_queue.size() == 0 && !item_valid && frames_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // stop and ramp both wheels fully down at the current settings
    task automatic settle_run();
        int mag;
        int steps;
        wait_drained();
        mag = (ramp_l < 0) ? -int'(ramp_l) : int'(ramp_l);
        if (ramp_r < 0 && -int'(ramp_r) > mag)
            mag = -int'(ramp_r);
        else if (ramp_r > mag)
            mag = ramp_r;
        steps = (cfg_ramp == '0) ? 2 : (mag + int'(cfg_ramp) - 1) / int'(cfg_ramp) + 2;
        push_item(ACT_COMMAND, DIR_STOP, $urandom, $urandom, $urandom);
        repeat (steps) push_tick();
        wait_drained();
    endtask

    task automatic push_random_phase(input int quota);
        int                 n;
        int                 runs;
        logic signed [31:0] cnt_l;
        logic signed [31:0] cnt_r;
        logic signed [31:0] dur;
        logic [2:0]         dir;
        n = 0;
        while (n < quota)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                case ($urandom_range(0, 2))
                    0: push_item(ACT_NONE, 3'($urandom), $urandom, $urandom, $urandom);
                    1: push_item(ACT_COMMAND, 3'($urandom_range(DIR_UNKNOWN, 7)),
                                 $urandom, $urandom, $urandom);
                    default:
                    begin
                        push_item(2'($urandom), 3'($urandom), $urandom, $urandom, $urandom);
                        n++;
                    end
                endcase
            end
            else
            begin
                cnt_l = $urandom;
                cnt_r = cnt_l + $urandom_range(0, 300);
                if ($urandom_range(0, 1) == 1)
                begin
                    push_item(ACT_ODO, 3'($urandom), $urandom, cnt_l, cnt_r);
                    n++;
                end
                dir = ($urandom_range(0, 1) == 1) ? DIR_FORWARD
                                                  : 3'($urandom_range(DIR_FORWARD, DIR_RIGHT));
                case ($urandom_range(0, 9))
                    0:       dur = 0;
                    1:       dur = -$urandom_range(1, 1000);
                    2, 3:    dur = $urandom | 32'h8000_0000;
                    9:       dur = $urandom & 32'h7fff_ffff;
                    default: dur = $urandom_range(1, 200);
                endcase
                push_item(ACT_COMMAND, dir, dur, $urandom, $urandom);
                n++;
                runs = $urandom_range(1, 12);
                repeat (runs)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        cnt_l = cnt_l + $urandom_range(0, 40);
                        cnt_r = cnt_r + $urandom_range(0, 40);
                        if ($urandom_range(0, 9) == 0)
                            cnt_r = $urandom;
                        push_item(ACT_ODO, 3'($urandom), $urandom, cnt_l, cnt_r);
                        n++;
                    end
                    push_tick();
                    n++;
                end
                if ($urandom_range(0, 9) < 6)
                begin
                    push_item(ACT_COMMAND, DIR_STOP, $urandom, $urandom, $urandom);
                    n++;
                    repeat ($urandom_range(2, 20))
                    begin
                        push_tick();
                        n++;
                    end
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                predict_frames(action, direction, run_length, odo_left_count, odo_right_count);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!item_valid || item_ready)
            begin
                if (word_queue.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_word = word_queue.pop_front();
                    item_valid      <= 1'b1;
                    action          <= next_word.act;
                    direction       <= next_word.dir;
                    run_length      <= next_word.dur_ms;
                    odo_left_count  <= next_word.left_cnt;
                    odo_right_count <= next_word.right_cnt;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ready <= 1'b0;
        end
        else
        begin
            if (frame_valid && frame_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    report_mismatch("unexpected frame, frame_kind", frame_kind, -1);
                end
                else
                begin
                    want_frame = frames_due.pop_front();
                    if (frame_kind !== want_frame.kind)
                        report_mismatch("frame_kind", frame_kind, want_frame.kind);
                    if (left_speed !== want_frame.left)
                        report_mismatch("left_speed", left_speed, want_frame.left);
                    if (right_speed !== want_frame.right)
                        report_mismatch("right_speed", right_speed, want_frame.right);
                    if (last !== want_frame.last)
                        report_mismatch("last", last, want_frame.last);
                end
            end
            frame_ready <= !rx_block && (calm || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // hold off the frame side while words keep coming
    initial
    begin
        wait (accepted_cnt >= HOLD_AFTER);
        @(posedge clk);
        rx_block <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_block <= 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_BASE_SPEED, 32'd30);
        write_reg(REG_RAMP_INC, 32'd10);
        write_reg(REG_POLL_TICKS, 32'd3);
        push_tick();
        push_item(ACT_NONE, 3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        push_item(ACT_COMMAND, DIR_UNKNOWN, 32'd500, 32'd0, 32'd0);
        push_item(ACT_COMMAND, 3'd7, 32'd500, 32'd0, 32'd0);
        push_item(ACT_COMMAND, DIR_STOP, 32'd0, 32'd0, 32'd0);
        push_item(ACT_ODO, DIR_STOP, 32'd0, 32'sd100, 32'sd100);
        push_item(ACT_COMMAND, DIR_FORWARD, 32'd0, 32'd0, 32'd0);
        repeat (3) push_tick();
        push_item(ACT_ODO, DIR_STOP, 32'd0, 32'sd100, 32'sd140);
        push_tick();
        push_item(ACT_ODO, DIR_STOP, 32'd0, 32'h8000_0000, 32'h7fff_ffff);
        push_tick();
        push_item(ACT_ODO, DIR_STOP, 32'd0, 32'h7fff_ffff, 32'h8000_0000);
        push_tick();
        push_item(ACT_COMMAND, DIR_STOP, 32'd0, 32'd0, 32'd0);
        repeat (3) push_tick();
        push_item(ACT_COMMAND, DIR_BACK, 32'sd1, 32'd0, 32'd0);
        repeat (2) push_tick();
        push_item(ACT_COMMAND, DIR_LEFT, 32'h8000_0000, 32'd0, 32'd0);
        push_tick();
        push_item(ACT_COMMAND, DIR_RIGHT, 32'h7fff_ffff, 32'd0, 32'd0);
        push_tick();
        settle_run();

        // frozen ramp and a status request on every tick
        write_reg(REG_RAMP_INC, 32'd0);
        write_reg(REG_POLL_TICKS, 32'd0);
        push_item(ACT_COMMAND, DIR_FORWARD, 32'sd10, 32'd0, 32'd0);
        repeat (3) push_tick();
        wait_drained();

        write_reg(REG_BASE_SPEED, 32'(BASE_SPEED_RESET));
        write_reg(REG_RAMP_INC, 32'(RAMP_INC_RESET));
        write_reg(REG_POLL_TICKS, 32'(POLL_TICKS_RESET));
        push_random_phase(30);
        settle_run();

        write_reg(REG_BASE_SPEED, 32'd21845);
        write_reg(REG_RAMP_INC, 32'd255);
        write_reg(REG_POLL_TICKS, 32'd255);
        push_random_phase(20);
        settle_run();

        write_reg(REG_BASE_SPEED, 32'd0);
        write_reg(REG_RAMP_INC, 32'd1);
        write_reg(REG_POLL_TICKS, 32'd1);
        push_random_phase(15);
        settle_run();

        write_reg(REG_BASE_SPEED, 32'($urandom_range(1, 2000)));
        write_reg(REG_RAMP_INC, 32'($urandom_range(1, 255)));
        write_reg(REG_POLL_TICKS, 32'($urandom_range(1, 255)));
        calm <= 1'b1;
        push_random_phase(25);
        wait_drained();

        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
